### rtl/fpa_pkg.sv
// Package for the Q24.8 fixed-point ALU: command codes, word types, constants.
// No dependencies.
package fpa_pkg;

	localparam int FractionBits = 8;
	localparam int QuoBits = 32 + FractionBits + 1;
	localparam int NumCells = QuoBits;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
		CMD_LT = 4'd4, CMD_GT = 4'd5, CMD_LE = 4'd6, CMD_GE = 4'd7,
		CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
		CMD_INC = 4'd12, CMD_TOFIX = 4'd13, CMD_TOINT = 4'd14, CMD_NONE = 4'd15
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIVZ = 2'd2, ST_RSV = 2'd3
	} status_t;

	typedef struct packed {
		logic [3:0] command;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic compare_true;
		logic [1:0] status;
	} out_word_t;

	// word travelling down the divider row
	typedef struct packed {
		logic valid;
		logic is_div;
		logic neg;
		logic divz;
		logic [QuoBits:0] rem;        // partial remainder, one bit wider than num
		logic [QuoBits-1:0] num;      // 2n+d, shifted out MSB first
		logic [QuoBits-1:0] quo;
		logic [32:0] den;             // 2d
		out_word_t other;             // result of non-divide commands
	} cell_t;

endpackage

### rtl/fpa_front.sv
// Front stage: decodes the command and computes all non-divide results.
// Depends on fpa_pkg.
module fpa_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic take,
	input  fpa_pkg::in_word_t in_word,
	output fpa_pkg::cell_t cell_out
);

	localparam int F = fpa_pkg::FractionBits;
	localparam int QB = fpa_pkg::QuoBits;

	logic signed [33:0] add_w, sub_w, inc_w;
	logic signed [63:0] prod;
	logic [63:0] pmag;
	logic [63:0] prnd;
	logic signed [64:0] mres;
	logic [31:0] amag, bmag;
	logic [31+F:0] fixmag;
	logic signed [32+F:0] fixv;
	logic [31:0] intmag;
	logic lt, eq;
	fpa_pkg::out_word_t o;
	fpa_pkg::cell_t c;

	function automatic fpa_pkg::out_word_t sat(input logic signed [64:0] v);
		fpa_pkg::out_word_t r;
		r.compare_true = 1'b0;
		if (v > 65'sd2147483647) begin
			r.result_value = 32'sh7fffffff;
			r.status = fpa_pkg::ST_OVF;
		end else if (v < -65'sd2147483648) begin
			r.result_value = 32'sh80000000;
			r.status = fpa_pkg::ST_OVF;
		end else begin
			r.result_value = v[31:0];
			r.status = fpa_pkg::ST_OK;
		end
		return r;
	endfunction

	// multiplier registered before rounding
	logic signed [63:0] prod_s1;
	logic [3:0] cmd_s1;
	logic valid_s1;

	always_comb begin
		add_w = 34'(in_word.operand_a) + 34'(in_word.operand_b);
		sub_w = 34'(in_word.operand_a) - 34'(in_word.operand_b);
		inc_w = 34'(in_word.operand_a) + 34'sd1;
		prod = 64'(in_word.operand_a) * 64'(in_word.operand_b);
		amag = in_word.operand_a[31] ? 32'(-in_word.operand_a) : in_word.operand_a;
		bmag = in_word.operand_b[31] ? 32'(-in_word.operand_b) : in_word.operand_b;
		fixmag = {amag, F'(0)};
		fixv = in_word.operand_a[31] ? -$signed({1'b0, fixmag}) : $signed({1'b0, fixmag});
		intmag = amag >> F;
		lt = in_word.operand_a < in_word.operand_b;
		eq = in_word.operand_a == in_word.operand_b;
		pmag = '0;
		prnd = '0;
		mres = '0;
		o = '0;
		case (fpa_pkg::cmd_t'(in_word.command))
			fpa_pkg::CMD_ADD: o = sat(65'(add_w));
			fpa_pkg::CMD_SUB: o = sat(65'(sub_w));
			fpa_pkg::CMD_INC: o = sat(65'(inc_w));
			fpa_pkg::CMD_TOFIX: o = sat(65'(fixv));
			fpa_pkg::CMD_TOINT: o.result_value = in_word.operand_a[31] ?
				-$signed(intmag) : $signed(intmag);
			fpa_pkg::CMD_LT: o.compare_true = lt;
			fpa_pkg::CMD_GT: o.compare_true = !lt && !eq;
			fpa_pkg::CMD_LE: o.compare_true = lt || eq;
			fpa_pkg::CMD_GE: o.compare_true = !lt;
			fpa_pkg::CMD_EQ: o.compare_true = eq;
			fpa_pkg::CMD_NE: o.compare_true = !eq;
			fpa_pkg::CMD_MIN: o.result_value = lt ? in_word.operand_a : in_word.operand_b;
			fpa_pkg::CMD_MAX: o.result_value = (!lt && !eq) ? in_word.operand_a :
				in_word.operand_b;
			default: o = '0;
		endcase
		// rounding of the product registered in prod_s1
		pmag = prod_s1[63] ? 64'(-prod_s1) : 64'(prod_s1);
		prnd = (pmag + (64'd1 << (F - 1))) >> F;
		mres = prod_s1[63] ? -$signed({1'b0, prnd}) : $signed({1'b0, prnd});

		c.valid = take;
		c.is_div = in_word.command == fpa_pkg::CMD_DIV;
		c.neg = in_word.operand_a[31] ^ in_word.operand_b[31];
		c.divz = in_word.operand_b == '0;
		c.rem = '0;
		c.num = {amag, F'(0), 1'b0} + QB'(bmag);
		c.quo = '0;
		c.den = {bmag, 1'b0};
		c.other = o;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
		end
	end

	// mul results are patched one stage later, in the first cell's slot
	logic mul_s1;
	fpa_pkg::cell_t c_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			cmd_s1 <= in_word.command;
			c_s1 <= c;
		end
	end

	always_comb begin
		mul_s1 = cmd_s1 == fpa_pkg::CMD_MUL;
		cell_out.valid = valid_s1;
		cell_out.is_div = c_s1.is_div;
		cell_out.neg = c_s1.neg;
		cell_out.divz = c_s1.divz;
		cell_out.rem = c_s1.rem;
		cell_out.num = c_s1.num;
		cell_out.quo = c_s1.quo;
		cell_out.den = c_s1.den;
		cell_out.other = mul_s1 ? sat(mres) : c_s1.other;
	end

endmodule

### rtl/fpa_cell.sv
// One restoring-division cell: produces one quotient bit and passes the word on.
// Depends on fpa_pkg.
module fpa_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  fpa_pkg::cell_t cell_in,
	output fpa_pkg::cell_t cell_out
);

	localparam int QB = fpa_pkg::QuoBits;

	logic [QB:0] trial;
	logic [QB+1:0] diff;
	fpa_pkg::cell_t nxt;

	always_comb begin
		trial = {cell_in.rem[QB-1:0], cell_in.num[QB-1]};
		diff = {1'b0, trial} - (QB+2)'(cell_in.den);
		nxt = cell_in;
		nxt.num = {cell_in.num[QB-2:0], 1'b0};
		if (!diff[QB+1]) begin
			nxt.rem = diff[QB:0];
			nxt.quo = {cell_in.quo[QB-2:0], 1'b1};
		end else begin
			nxt.rem = trial;
			nxt.quo = {cell_in.quo[QB-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_out.valid <= 1'b0;
		end else if (en) begin
			cell_out <= nxt;
		end
	end

endmodule

### rtl/fixed_point_q24_8_alu.sv
// Top level of the Q24.8 fixed-point ALU: front stage, row of divider cells, output skid.
// Depends on fpa_pkg, fpa_front, fpa_cell.
//
//  channel   signals                      dir   word
//  in        in_valid in_ready in_data    in    fpa_pkg::in_word_t
//  out       out_valid out_ready out_data out   fpa_pkg::out_word_t
//
// One word per cycle while the pipe is not stalled; every command passes the front stage,
// one divider cell per quotient bit of the 41-bit quotient, and the result stage.
// The whole pipe advances together; a stall on out holds every stage.
// A two-entry output buffer lets in keep taking words while the head waits.
// Reset clears all valid bits; no clearing pass.
module fixed_point_q24_8_alu (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  fpa_pkg::in_word_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output fpa_pkg::out_word_t out_data
);

	localparam int N = fpa_pkg::NumCells;
	localparam int QB = fpa_pkg::QuoBits;

	fpa_pkg::cell_t row [0:N];
	logic en;
	logic take;
	fpa_pkg::out_word_t fin;
	fpa_pkg::out_word_t buf_q [0:1];
	logic [1:0] cnt_q;
	logic [QB-1:0] q;
	logic [QB:0] qs;
	logic pop, push;

	// stall pipe only when buffer cannot hold what is in flight at the tail
	assign en = (cnt_q != 2'd2) || !row[N].valid;
	assign in_ready = en;
	assign take = in_valid && in_ready;

	fpa_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .take(take),
		.in_word(in_data), .cell_out(row[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		fpa_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.cell_in(row[i]), .cell_out(row[i+1])
		);
	end

	always_comb begin
		q = row[N].quo;
		// q = floor((2n+d)/(2d)), which is n/d rounded to nearest
		qs = {1'b0, q};
		fin = row[N].other;
		if (row[N].is_div) begin
			fin = '0;
			if (row[N].divz) begin
				fin.status = fpa_pkg::ST_DIVZ;
			end else if (!row[N].neg && qs > (QB+1)'(32'h7fffffff)) begin
				fin.result_value = 32'sh7fffffff;
				fin.status = fpa_pkg::ST_OVF;
			end else if (row[N].neg && qs > (QB+1)'(33'h080000000)) begin
				fin.result_value = 32'sh80000000;
				fin.status = fpa_pkg::ST_OVF;
			end else begin
				fin.result_value = row[N].neg ? 32'(-q[31:0]) : q[31:0];
			end
		end
	end

	assign pop = out_valid && out_ready;
	assign push = en && row[N].valid;
	assign out_valid = cnt_q != 2'd0;
	assign out_data = buf_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= 2'(cnt_q + 2'(push) - 2'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			buf_q[0] <= (cnt_q == 2'd2) ? buf_q[1] : fin;
			if (push) begin
				buf_q[1] <= fin;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				buf_q[0] <= fin;
			end else begin
				buf_q[1] <= fin;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("output buffer overfilled");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(cnt_q) || $past(pop)) else $error("buffer moved while stalled");
	a_divz_status: assert property (@(posedge clk) disable iff (!arst_n)
		push && row[N].is_div && row[N].divz |-> fin.status == fpa_pkg::ST_DIVZ)
		else $error("divide by zero status lost");

endmodule
